// ----- hdl/humidity_sensor_two_wire_master_macros.svh -----
// Assertion macros shared by the two-wire sensor master RTL.
// Depends on nothing; modules that assert include this header by name.
`ifndef HUMIDITY_SENSOR_TWO_WIRE_MASTER_MACROS_SVH
`define HUMIDITY_SENSOR_TWO_WIRE_MASTER_MACROS_SVH

// Property checked at every rising edge of i_clk while reset is released.
`define HSTW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property checked at every rising edge of i_clk, reset included.
`define HSTW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- hdl/hstw_pkg.sv -----
// Package for the two-wire sensor master: phase encoding, result struct,
// start sequence table and CRC-8 step. Used by hstw_core and the top level.
package hstw_pkg;

    localparam int          RESET_PULSES_DEF = 10;
    localparam logic [7:0]  TICKS_RESET      = 8'd10;
    localparam logic [7:0]  SOFT_RESET_CMD   = 8'd30;
    localparam int          INIT_STEPS       = 7;
    localparam int          CMD_BITS         = 8;
    localparam int          DATA_BYTES       = 2;
    localparam logic [7:0]  CRC_TAP_XOR      = 8'h30;

    localparam logic [1:0]  OP_TICK    = 2'd0;
    localparam logic [1:0]  OP_MEASURE = 2'd1;
    localparam logic [1:0]  OP_RESET   = 2'd2;

    localparam logic [0:0]  REG_TICKS  = 1'b0;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_M_REL  = 5'd1,
        PH_M_INIT = 5'd2,
        PH_M_CD   = 5'd3,
        PH_M_CH   = 5'd4,
        PH_M_CL   = 5'd5,
        PH_M_AR   = 5'd6,
        PH_M_AH   = 5'd7,
        PH_M_AL   = 5'd8,
        PH_M_WAIT = 5'd9,
        PH_M_RH   = 5'd10,
        PH_M_RL   = 5'd11,
        PH_M_BD   = 5'd12,
        PH_M_BH   = 5'd13,
        PH_M_BL   = 5'd14,
        PH_M_BU   = 5'd15,
        PH_M_FD   = 5'd16,
        PH_M_FH   = 5'd17,
        PH_M_FL   = 5'd18,
        PH_M_FU   = 5'd19,
        PH_R_H    = 5'd20,
        PH_R_L    = 5'd21,
        PH_R_INIT = 5'd22,
        PH_R_CD   = 5'd23,
        PH_R_CH   = 5'd24,
        PH_R_CL   = 5'd25,
        PH_R_AR   = 5'd26,
        PH_R_AH   = 5'd27,
        PH_R_AL   = 5'd28
    } t_phase;

    typedef enum logic [1:0] {
        ACT_REL_DATA = 2'd0,
        ACT_CLK_HIGH = 2'd1,
        ACT_DATA_LOW = 2'd2,
        ACT_CLK_LOW  = 2'd3
    } t_line_act;

    typedef struct packed {
        logic [15:0] value;
        logic        status;
        logic        done;
        logic        busy;
        logic        data_low;
        logic        sck;
    } t_result;

    // Line action for each step of the start sequence.
    function automatic t_line_act start_action(input logic [2:0] idx);
        t_line_act act;
        unique case (idx)
            3'd0:    act = ACT_REL_DATA;
            3'd1:    act = ACT_CLK_HIGH;
            3'd2:    act = ACT_DATA_LOW;
            3'd3:    act = ACT_CLK_LOW;
            3'd4:    act = ACT_CLK_HIGH;
            3'd5:    act = ACT_REL_DATA;
            3'd6:    act = ACT_CLK_LOW;
            default: act = ACT_REL_DATA;
        endcase
        return act;
    endfunction

    // One bit of CRC-8, polynomial x^8+x^5+x^4+1, shifted MSB first.
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic b);
        logic       t;
        logic [7:0] c;
        t = b ^ crc[7];
        c = {crc[6:0], t};
        if (t) begin
            c = c ^ CRC_TAP_XOR;
        end
        return c;
    endfunction

endpackage

// ----- hdl/hstw_core.sv -----
// Bus phase sequencer of the two-wire sensor master: state registers,
// next-phase logic and the per-tick result. Depends on hstw_pkg and the macro header.
`include "humidity_sensor_two_wire_master_macros.svh"

module hstw_core #(
    parameter int RESET_PULSES = hstw_pkg::RESET_PULSES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [1:0]           i_op,
    input  logic [7:0]           i_command,
    input  logic                 i_data_in,
    input  logic [7:0]           i_ticks,
    output hstw_pkg::t_result    o_res
);
    import hstw_pkg::*;

    localparam int BitW = $clog2(RESET_PULSES + 1);

    t_phase         r_phase, n_phase;
    logic [7:0]     r_tick_count, n_tick, n_tick_base;
    logic [BitW-1:0] r_bit_count, n_bit, bit_inc;
    logic [1:0]     r_byte_count, n_byte;
    logic [7:0]     r_saved_command, n_saved;
    logic [7:0]     r_shift_out, n_shift;
    logic [7:0]     r_running_crc, n_crc;
    logic [15:0]    r_data_shift, n_data_shift;
    logic [7:0]     r_received_check, n_rcheck;
    logic           r_clock, n_clock;
    logic           r_data, n_data;
    logic           r_resume, n_resume;

    logic           do_enter;
    logic           read_now;
    logic           fin;
    logic           fin_status;
    logic [15:0]    fin_value;
    logic [7:0]     hold_m1;
    t_line_act      act;
    logic           measure_go;

    assign hold_m1 = (i_ticks == 8'd0) ? 8'd0 : (i_ticks - 8'd1);
    assign bit_inc = r_bit_count + BitW'(1);
    assign measure_go = i_step && (r_phase == PH_IDLE) && (i_op == OP_MEASURE);

    // Next phase and bookkeeping registers.
    always_comb begin
        n_phase      = r_phase;
        n_tick_base  = r_tick_count;
        n_bit        = r_bit_count;
        n_byte       = r_byte_count;
        n_saved      = r_saved_command;
        n_shift      = r_shift_out;
        n_crc        = r_running_crc;
        n_data_shift = r_data_shift;
        n_rcheck     = r_received_check;
        n_resume     = r_resume;
        do_enter     = 1'b0;
        read_now     = 1'b0;
        fin          = 1'b0;
        fin_status   = 1'b0;
        fin_value    = 16'd0;
        if (i_step) begin
            if (r_phase == PH_IDLE) begin
                if (i_op == OP_MEASURE) begin
                    n_saved  = i_command;
                    n_crc    = 8'd0;
                    n_bit    = '0;
                    n_byte   = 2'd0;
                    n_phase  = PH_M_REL;
                    do_enter = 1'b1;
                end else if (i_op == OP_RESET) begin
                    n_resume = 1'b0;
                    n_bit    = '0;
                    n_phase  = PH_R_H;
                    do_enter = 1'b1;
                end
            end else if ((r_phase == PH_M_WAIT) || (r_tick_count == 8'd0)) begin
                do_enter = 1'b1;
                unique case (r_phase)
                    PH_M_REL: begin
                        n_bit   = '0;
                        n_phase = PH_M_INIT;
                    end
                    PH_M_INIT, PH_R_INIT: begin
                        if (bit_inc < BitW'(INIT_STEPS)) begin
                            n_bit = bit_inc;
                        end else begin
                            n_bit = '0;
                            if (r_phase == PH_M_INIT) begin
                                n_shift = r_saved_command;
                                n_phase = PH_M_CD;
                            end else begin
                                n_shift = SOFT_RESET_CMD;
                                n_phase = PH_R_CD;
                            end
                        end
                    end
                    PH_M_CD: begin
                        n_crc   = crc_step(r_running_crc, r_shift_out[7]);
                        n_phase = PH_M_CH;
                    end
                    PH_M_CH: n_phase = PH_M_CL;
                    PH_M_CL, PH_R_CL: begin
                        n_shift = {r_shift_out[6:0], 1'b0};
                        n_bit   = bit_inc;
                        if (r_phase == PH_M_CL) begin
                            n_phase = (bit_inc < BitW'(CMD_BITS)) ? PH_M_CD : PH_M_AR;
                        end else begin
                            n_phase = (bit_inc < BitW'(CMD_BITS)) ? PH_R_CD : PH_R_AR;
                        end
                    end
                    PH_M_AR: begin
                        if (i_data_in) begin
                            do_enter    = 1'b0;
                            fin         = 1'b1;
                            fin_status  = 1'b1;
                            n_phase     = PH_IDLE;
                            n_tick_base = 8'd0;
                        end else begin
                            n_phase = PH_M_AH;
                        end
                    end
                    PH_M_AH: n_phase = PH_M_AL;
                    PH_M_AL: begin
                        do_enter    = 1'b0;
                        n_phase     = PH_M_WAIT;
                        n_tick_base = 8'd0;
                        n_bit       = '0;
                        n_byte      = 2'd0;
                        read_now    = !i_data_in;
                    end
                    PH_M_WAIT: begin
                        do_enter = 1'b0;
                        read_now = !i_data_in;
                    end
                    PH_M_RH: n_phase = PH_M_RL;
                    PH_M_RL: begin
                        n_bit = bit_inc;
                        if (bit_inc < BitW'(CMD_BITS)) begin
                            do_enter = 1'b0;
                            read_now = 1'b1;
                        end else if (r_byte_count < 2'(DATA_BYTES)) begin
                            n_phase = PH_M_BD;
                        end else if (r_received_check == r_running_crc) begin
                            n_phase = PH_M_FD;
                        end else begin
                            // Checksum mismatch: reset the connection, then measure again.
                            n_resume = 1'b1;
                            n_bit    = '0;
                            n_phase  = PH_R_H;
                        end
                    end
                    PH_M_BD: n_phase = PH_M_BH;
                    PH_M_BH: n_phase = PH_M_BL;
                    PH_M_BL: n_phase = PH_M_BU;
                    PH_M_BU: begin
                        do_enter = 1'b0;
                        n_byte   = r_byte_count + 2'd1;
                        n_bit    = '0;
                        read_now = 1'b1;
                    end
                    PH_M_FD: n_phase = PH_M_FH;
                    PH_M_FH: n_phase = PH_M_FL;
                    PH_M_FL: n_phase = PH_M_FU;
                    PH_M_FU: begin
                        do_enter    = 1'b0;
                        fin         = 1'b1;
                        fin_value   = r_data_shift;
                        n_phase     = PH_IDLE;
                        n_tick_base = 8'd0;
                    end
                    PH_R_H: n_phase = PH_R_L;
                    PH_R_L: begin
                        if (bit_inc < BitW'(RESET_PULSES)) begin
                            n_bit   = bit_inc;
                            n_phase = PH_R_H;
                        end else begin
                            n_bit   = '0;
                            n_phase = PH_R_INIT;
                        end
                    end
                    PH_R_CD: n_phase = PH_R_CH;
                    PH_R_CH: n_phase = PH_R_CL;
                    PH_R_AR: n_phase = PH_R_AH;
                    PH_R_AH: n_phase = PH_R_AL;
                    PH_R_AL: begin
                        if (r_resume) begin
                            n_crc   = 8'd0;
                            n_bit   = '0;
                            n_byte  = 2'd0;
                            n_phase = PH_M_REL;
                        end else begin
                            do_enter    = 1'b0;
                            fin         = 1'b1;
                            n_phase     = PH_IDLE;
                            n_tick_base = 8'd0;
                        end
                    end
                    default: begin
                        do_enter    = 1'b0;
                        fin         = 1'b1;
                        n_phase     = PH_IDLE;
                        n_tick_base = 8'd0;
                    end
                endcase
            end else begin
                n_tick_base = r_tick_count - 8'd1;
            end
        end
        // Sample one data bit: data bytes go into the shift word and the CRC,
        // checksum bits arrive LSB first.
        if (read_now) begin
            if (n_byte < 2'(DATA_BYTES)) begin
                n_data_shift = {r_data_shift[14:0], i_data_in};
                n_crc        = crc_step(r_running_crc, i_data_in);
            end else begin
                n_rcheck = {i_data_in, r_received_check[7:1]};
            end
            n_phase  = PH_M_RH;
            do_enter = 1'b1;
        end
    end

    // Line change and hold count on entering a phase.
    always_comb begin
        n_tick  = n_tick_base;
        n_clock = r_clock;
        n_data  = r_data;
        act     = start_action((n_bit < BitW'(INIT_STEPS)) ? n_bit[2:0] : 3'd0);
        if (do_enter) begin
            n_tick = hold_m1;
            unique case (n_phase)
                PH_M_REL, PH_M_AR, PH_M_BU, PH_M_FU, PH_R_AR: n_data = 1'b0;
                PH_M_BD, PH_M_FD: n_data = 1'b1;
                PH_M_INIT, PH_R_INIT: begin
                    unique case (act)
                        ACT_REL_DATA: n_data  = 1'b0;
                        ACT_CLK_HIGH: n_clock = 1'b1;
                        ACT_DATA_LOW: n_data  = 1'b1;
                        ACT_CLK_LOW:  n_clock = 1'b0;
                        default:      n_data  = 1'b0;
                    endcase
                end
                PH_M_CD, PH_R_CD: n_data = ~n_shift[7];
                PH_M_CH, PH_M_AH, PH_M_RH, PH_M_BH, PH_M_FH,
                PH_R_H, PH_R_CH, PH_R_AH: n_clock = 1'b1;
                PH_M_CL, PH_M_AL, PH_M_RL, PH_M_BL, PH_M_FL,
                PH_R_L, PH_R_CL, PH_R_AL: n_clock = 1'b0;
                default: n_tick = 8'd0;
            endcase
        end
    end

    // Result of this tick.
    always_comb begin
        o_res.sck      = n_clock;
        o_res.data_low = n_data;
        o_res.busy     = (n_phase != PH_IDLE);
        o_res.done     = fin;
        o_res.status   = fin & fin_status;
        o_res.value    = (fin && !fin_status) ? fin_value : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_tick_count     <= 8'd0;
            r_bit_count      <= '0;
            r_byte_count     <= 2'd0;
            r_saved_command  <= 8'd0;
            r_shift_out      <= 8'd0;
            r_running_crc    <= 8'd0;
            r_data_shift     <= 16'd0;
            r_received_check <= 8'd0;
            r_clock          <= 1'b0;
            r_data           <= 1'b0;
            r_resume         <= 1'b0;
        end else begin
            r_phase          <= n_phase;
            r_tick_count     <= n_tick;
            r_bit_count      <= n_bit;
            r_byte_count     <= n_byte;
            r_saved_command  <= n_saved;
            r_shift_out      <= n_shift;
            r_running_crc    <= n_crc;
            r_data_shift     <= n_data_shift;
            r_received_check <= n_rcheck;
            r_clock          <= n_clock;
            r_data           <= n_data;
            r_resume         <= n_resume;
        end
    end

    `HSTW_ASSERT(a_done_goes_idle, o_res.done |-> !o_res.busy, "done while still busy")
    `HSTW_ASSERT(a_byte_range, r_byte_count != 2'd3, "byte count out of range")
    `HSTW_ASSERT(a_hold_without_step, !i_step |=> $stable(r_phase), "phase moved without tick")
    `HSTW_ASSERT(a_measure_start, measure_go |=> (r_phase == PH_M_REL), "no measurement start")
    `HSTW_ASSERT(a_fail_no_value, o_res.status |-> (o_res.done && !(|o_res.value)), "bad status")

endmodule

// ----- hdl/humidity_sensor_two_wire_master.sv -----
// The result of an accepted item sits in the output register in the cycle after it is accepted.
// Throughput: one item per clock cycle; per item the phase sequencer in hstw_core either
// counts down the hold of the current bus phase or moves to the next phase. A stalled result
// holds the input off only while the output register is full and not being drained.
// Reset (i_rst_n low, synchronous): sequencer idle, lines released, clock low,
// ticks_per_phase back to 10, output register empty.
module humidity_sensor_two_wire_master #(
    parameter int RESET_PULSES = hstw_pkg::RESET_PULSES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] command, [8] data_in, [15:9] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [0] sck, [1] data_low, [2] busy_res,
                                        // [3] done_res, [4] status, [20:5] value, [23:21] zero
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hstw_pkg::*;

    logic        r_m_valid;
    logic [23:0] r_m_data;
    logic [7:0]  r_ticks;
    logic        s_accept;
    logic        cfg_write;
    t_result     step_res;

    // A new item is taken whenever the output register is empty or is being
    // drained in this same cycle, so the sequencer advances at full rate.
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // The single register ticks_per_phase sits at byte address 0; the upper
    // address bit selects the register, byte offsets within it are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_TICKS);
    assign prdata    = (paddr[2] == REG_TICKS) ? {24'd0, r_ticks} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= TICKS_RESET;
        end else if (cfg_write) begin
            r_ticks <= pwdata[7:0];
        end
    end

    // The sequencer holds all bus state and takes one tick of its current phase per accepted item.
    hstw_core #(
        .RESET_PULSES (RESET_PULSES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (s_accept),
        .i_op      (s_axis_tuser),
        .i_command (s_axis_tdata[7:0]),
        .i_data_in (s_axis_tdata[8]),
        .i_ticks   (r_ticks),
        .o_res     (step_res)
    );

    // Output register: valid is control state, data is loaded on each accept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_accept) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_m_data <= {3'd0, step_res.value, step_res.status, step_res.done,
                         step_res.busy, step_res.data_low, step_res.sck};
        end
    end

endmodule
